[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

// Next-cycle implication that is checked during reset as well.
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

[hw/rtl/atl_pkg.sv]
// ----------------------------------------------------------------------------
// atl_pkg
// Types and constants shared by the arithmetic token lexer modules.
// ----------------------------------------------------------------------------
package atl_pkg;

  localparam int ACC_W          = 63;
  localparam int LINE_BITS_DEF  = 24;
  localparam int RES_DEPTH      = 4;

  localparam logic [ACC_W-1:0] NUM_MAX = {ACC_W{1'b1}};

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;

  typedef enum logic [2:0] {
    KIND_PLUS  = 3'd0,
    KIND_MINUS = 3'd1,
    KIND_STAR  = 3'd2,
    KIND_SLASH = 3'd3,
    KIND_INT   = 3'd4,
    KIND_END   = 3'd5,
    KIND_ERR   = 3'd6
  } kind_t;

  // Results of one character: up to two tokens. The second one, when
  // present, is always an operator or end token with a zero value.
  typedef struct packed {
    logic [1:0]       count;
    kind_t            kind0;
    logic [ACC_W-1:0] value0;
    logic             last0;
    kind_t            kind1;
  } step_res_t;

endpackage

[hw/rtl/atl_step.sv]
// ----------------------------------------------------------------------------
// atl_step
// Classifies one character and computes the tokens it produces and the next
// lexer state.
// ----------------------------------------------------------------------------
module atl_step #(
  parameter int LINE_BITS = atl_pkg::LINE_BITS_DEF
) (
  input  logic [7:0]               ch,
  input  logic                     in_number,
  input  logic [atl_pkg::ACC_W-1:0] acc,
  input  logic [LINE_BITS-1:0]     line_cnt,
  input  logic                     halted,
  output atl_pkg::step_res_t       res,
  output logic                     in_number_next,
  output logic [atl_pkg::ACC_W-1:0] acc_next,
  output logic [LINE_BITS-1:0]     line_next,
  output logic                     halted_next
);
  import atl_pkg::*;

  logic                 is_digit;
  logic                 is_op;
  kind_t                op_kind;
  logic                 is_brk;
  logic                 is_ws;
  logic                 is_semi;
  logic                 is_nul;
  logic [LINE_BITS-1:0] line_inc;
  logic [ACC_W+3:0]     acc_x10;
  logic [ACC_W+3:0]     acc_sum;
  logic [ACC_W-1:0]     acc_sat;

  always_comb begin
    is_op   = 1'b0;
    op_kind = KIND_PLUS;
    case (ch)
      CH_PLUS:  begin is_op = 1'b1; op_kind = KIND_PLUS;  end
      CH_MINUS: begin is_op = 1'b1; op_kind = KIND_MINUS; end
      CH_STAR:  begin is_op = 1'b1; op_kind = KIND_STAR;  end
      CH_SLASH: begin is_op = 1'b1; op_kind = KIND_SLASH; end
      default:  begin is_op = 1'b0; op_kind = KIND_PLUS;  end
    endcase
  end

  assign is_digit = ch inside {[CH_ZERO:CH_NINE]};
  assign is_brk   = ch inside {CH_FF, CH_CR, CH_LF};
  assign is_ws    = is_brk || (ch == CH_SPACE);
  assign is_semi  = (ch == CH_SEMI);
  assign is_nul   = (ch == CH_NUL);

  assign line_inc = (&line_cnt) ? line_cnt : line_cnt + 1'b1;

  // acc * 10 + digit as two shifted adds; anything above 63 bits saturates.
  assign acc_x10 = ({4'b0, acc} << 3) + ({4'b0, acc} << 1);
  assign acc_sum = acc_x10 + {{ACC_W{1'b0}}, ch[3:0]};
  assign acc_sat = (acc_sum[ACC_W+3:ACC_W] != 4'b0) ? NUM_MAX : acc_sum[ACC_W-1:0];

  always_comb begin
    res            = '0;
    res.kind0      = KIND_PLUS;
    res.kind1      = KIND_PLUS;
    in_number_next = in_number;
    acc_next       = acc;
    line_next      = line_cnt;
    halted_next    = halted;
    if (halted) begin
      res.count = 2'd0;
    end else if (is_digit) begin
      in_number_next = 1'b1;
      acc_next       = in_number ? acc_sat : {{(ACC_W-4){1'b0}}, ch[3:0]};
    end else if (in_number) begin
      in_number_next = 1'b0;
      acc_next       = '0;
      if (!is_op && !is_ws && !is_semi && !is_nul) begin
        // A bad character drops the pending number.
        halted_next = 1'b1;
        res.count   = 2'd1;
        res.kind0   = KIND_ERR;
        res.last0   = 1'b1;
      end else begin
        res.kind0  = KIND_INT;
        res.value0 = acc;
        if (is_semi || is_ws) begin
          res.count = 2'd1;
          res.last0 = 1'b1;
          if (is_brk) begin
            line_next = line_inc;
          end
        end else begin
          res.count = 2'd2;
          res.kind1 = is_op ? op_kind : KIND_END;
        end
      end
    end else if (is_ws) begin
      if (is_brk) begin
        line_next = line_inc;
      end
    end else begin
      res.count = 2'd1;
      res.last0 = 1'b1;
      if (is_op) begin
        res.kind0 = op_kind;
      end else if (is_nul) begin
        res.kind0 = KIND_END;
      end else begin
        res.kind0   = KIND_ERR;
        halted_next = 1'b1;
      end
    end
  end

endmodule

[hw/rtl/arithmetic_token_lexer.sv]
// ----------------------------------------------------------------------------
// arithmetic_token_lexer
// Lexes an ASCII stream into operator, integer, end and error tokens.
// ----------------------------------------------------------------------------
// The lexer takes one character per cycle into an input register and turns it
// combinationally into zero, one or two tokens, writing them into a four-entry
// result queue; the queue hands out one token per cycle while token_ready is
// high. A character is taken every cycle as long as the queue has room for
// the tokens that the registered character will produce, so the sustained
// rate is one character per cycle, limited by the single-token output port
// when numbers end on an operator or end-of-text character (two tokens each).
// A token reaches the output once its character has passed the input
// register and been written into the result queue. After a syntax error the
// lexer swallows all characters until reset.
module arithmetic_token_lexer #(
  parameter int LINE_BITS = atl_pkg::LINE_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      char_valid,
  output logic                      char_ready,
  input  logic [7:0]                char_byte,
  output logic                      token_valid,
  input  logic                      token_ready,
  output logic [2:0]                token_kind,
  output logic [atl_pkg::ACC_W-1:0] int_value,
  output logic [LINE_BITS-1:0]      line_count,
  output logic                      last_of_run
);
  import atl_pkg::*;

  localparam int PTR_W = $clog2(RES_DEPTH);
  localparam int CNT_W = PTR_W + 1;

  logic                 in_vld;
  logic [7:0]           in_char;
  logic                 in_number;
  logic [ACC_W-1:0]     acc;
  logic [LINE_BITS-1:0] line_cnt;
  logic                 halted;

  step_res_t            res;
  logic                 in_number_next;
  logic [ACC_W-1:0]     acc_next;
  logic [LINE_BITS-1:0] line_next;
  logic                 halted_next;

  logic [2:0]           q_kind  [RES_DEPTH];
  logic [ACC_W-1:0]     q_value [RES_DEPTH];
  logic [LINE_BITS-1:0] q_line  [RES_DEPTH];
  logic                 q_last  [RES_DEPTH];
  logic [PTR_W-1:0]     wr_ptr;
  logic [PTR_W-1:0]     rd_ptr;
  logic [CNT_W-1:0]     count;
  logic [CNT_W-1:0]     count_next;
  logic [CNT_W-1:0]     free;
  logic [CNT_W-1:0]     push_n;
  logic                 advance;
  logic                 pop;

  atl_step #(
    .LINE_BITS (LINE_BITS)
  ) u_step (
    .ch             (in_char),
    .in_number      (in_number),
    .acc            (acc),
    .line_cnt       (line_cnt),
    .halted         (halted),
    .res            (res),
    .in_number_next (in_number_next),
    .acc_next       (acc_next),
    .line_next      (line_next),
    .halted_next    (halted_next)
  );

  assign free       = CNT_W'(RES_DEPTH) - count;
  assign push_n     = CNT_W'(res.count);
  assign advance    = in_vld && (free >= push_n);
  assign char_ready = !in_vld || advance;
  assign pop        = token_valid && token_ready;
  assign count_next = count + (advance ? push_n : '0) - CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (char_valid && char_ready) begin
      in_vld <= 1'b1;
    end else if (advance) begin
      in_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (char_valid && char_ready) begin
      in_char <= char_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_number <= 1'b0;
      acc       <= '0;
      line_cnt  <= LINE_BITS'(1);
      halted    <= 1'b0;
    end else if (advance) begin
      in_number <= in_number_next;
      acc       <= acc_next;
      line_cnt  <= line_next;
      halted    <= halted_next;
    end
  end

  // Result queue: up to two entries written per character, one read per cycle while token_ready is high.
  always_ff @(posedge clk) begin
    if (advance && (res.count != 2'd0)) begin
      q_kind[wr_ptr]  <= res.kind0;
      q_value[wr_ptr] <= res.value0;
      q_line[wr_ptr]  <= line_cnt;
      q_last[wr_ptr]  <= res.last0;
    end
    if (advance && (res.count == 2'd2)) begin
      q_kind[wr_ptr + 1'b1]  <= res.kind1;
      q_value[wr_ptr + 1'b1] <= '0;
      q_line[wr_ptr + 1'b1]  <= line_cnt;
      q_last[wr_ptr + 1'b1]  <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (advance) begin
        wr_ptr <= wr_ptr + PTR_W'(res.count);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count_next;
    end
  end

  assign token_valid = (count != '0);
  assign token_kind  = q_kind[rd_ptr];
  assign int_value   = q_value[rd_ptr];
  assign line_count  = q_line[rd_ptr];
  assign last_of_run = q_last[rd_ptr];

endmodule

[hw/rtl/atl_checker.sv]
// ----------------------------------------------------------------------------
// atl_checker
// Port-level checks for the arithmetic token lexer, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module atl_checker #(
  parameter int LINE_BITS = atl_pkg::LINE_BITS_DEF
) (
  input logic                      clk,
  input logic                      rst,
  input logic                      token_valid,
  input logic                      token_ready,
  input logic [2:0]                token_kind,
  input logic [atl_pkg::ACC_W-1:0] int_value,
  input logic [LINE_BITS-1:0]      line_count,
  input logic                      last_of_run
);
  import atl_pkg::*;

  // No token may be pending right after reset.
  `ASSERT_NEXT_ALWAYS(a_empty_after_reset, clk, rst, !token_valid)

  // A stalled token holds its contents.
  `ASSERT_NEXT(a_token_hold, clk, rst, token_valid && !token_ready, token_valid && $stable(token_kind) && $stable(int_value) && $stable(line_count) && $stable(last_of_run))

  // Only an integer token can be followed by another token of the same item.
  `ASSERT_IMPLIES(a_first_is_int, clk, rst, token_valid && !last_of_run, token_kind == KIND_INT)

  // Non-integer tokens carry a zero value.
  `ASSERT_IMPLIES(a_zero_value, clk, rst, token_valid && (token_kind != KIND_INT), int_value == '0)

  // Line numbers start at one and never wrap to zero.
  `ASSERT_IMPLIES(a_line_nonzero, clk, rst, token_valid, line_count != '0)

endmodule

bind arithmetic_token_lexer atl_checker #(
  .LINE_BITS (LINE_BITS)
) u_atl_checker (
  .clk         (clk),
  .rst         (rst),
  .token_valid (token_valid),
  .token_ready (token_ready),
  .token_kind  (token_kind),
  .int_value   (int_value),
  .line_count  (line_count),
  .last_of_run (last_of_run)
);

[tb/arithmetic_token_lexer_checker.sv]
// ----------------------------------------------------------------------------
// arithmetic_token_lexer_checker
// Watches both channels of the token lexer, predicts the tokens of every
// accepted character and compares each accepted token field by field.
// ----------------------------------------------------------------------------
module arithmetic_token_lexer_checker #(
  parameter int LINE_BITS = atl_pkg::LINE_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      char_valid,
  input  logic                      char_ready,
  input  logic [7:0]                char_byte,
  input  logic                      token_valid,
  input  logic                      token_ready,
  input  logic [2:0]                token_kind,
  input  logic [atl_pkg::ACC_W-1:0] int_value,
  input  logic [LINE_BITS-1:0]      line_count,
  input  logic                      last_of_run,
  output int                        fail_count,
  output int                        pending,
  output int                        tokens_seen
);
  import atl_pkg::*;

  typedef struct packed {
    kind_t                kind;
    logic [ACC_W-1:0]     value;
    logic [LINE_BITS-1:0] line;
    logic                 last;
  } token_t;

  token_t expected_tokens[$];

  // Shadow copy of the lexer state.
  logic                 in_number;
  logic [ACC_W-1:0]     accum;
  logic [LINE_BITS-1:0] line_cnt;
  logic                 halted;

  int n_fail = 0;
  int n_tokens = 0;

  logic [7:0]           ch;
  logic [LINE_BITS-1:0] line_now;
  logic [ACC_W-1:0]     digit;
  logic                 is_op, is_brk, is_ws;
  kind_t                op_kind;
  token_t               want;

  function automatic void push_token(kind_t kind, logic [ACC_W-1:0] value,
                                     logic [LINE_BITS-1:0] line, logic last);
    token_t t;
    t.kind  = kind;
    t.value = value;
    t.line  = line;
    t.last  = last;
    expected_tokens.push_back(t);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      in_number = 1'b0;
      accum     = '0;
      line_cnt  = LINE_BITS'(1);
      halted    = 1'b0;
      expected_tokens.delete();
    end else begin
      if (token_valid && token_ready) begin
        n_tokens++;
        if (expected_tokens.size() == 0) begin
          $error("token_kind: expected no token, got %0d", token_kind);
          n_fail++;
        end else begin
          want = expected_tokens.pop_front();
          if (token_kind !== want.kind) begin
            $error("token_kind: expected %0d, got %0d", want.kind, token_kind);
            n_fail++;
          end
          if (int_value !== want.value) begin
            $error("int_value: expected %0d, got %0d", want.value, int_value);
            n_fail++;
          end
          if (line_count !== want.line) begin
            $error("line_count: expected %0d, got %0d", want.line, line_count);
            n_fail++;
          end
          if (last_of_run !== want.last) begin
            $error("last_of_run: expected %0d, got %0d", want.last, last_of_run);
            n_fail++;
          end
        end
      end

      if (char_valid && char_ready && !halted) begin
        ch       = char_byte;
        line_now = line_cnt;
        is_brk   = (ch == CH_FF) || (ch == CH_CR) || (ch == CH_LF);
        is_ws    = is_brk || (ch == CH_SPACE);
        is_op    = 1'b1;
        op_kind  = KIND_PLUS;
        case (ch)
          CH_PLUS:  op_kind = KIND_PLUS;
          CH_MINUS: op_kind = KIND_MINUS;
          CH_STAR:  op_kind = KIND_STAR;
          CH_SLASH: op_kind = KIND_SLASH;
          default:  is_op = 1'b0;
        endcase

        if (ch >= CH_ZERO && ch <= CH_NINE) begin
          digit = ACC_W'(ch - CH_ZERO);
          if (!in_number) begin
            in_number = 1'b1;
            accum     = digit;
          end else if (accum > (NUM_MAX - digit) / 10) begin
            accum = NUM_MAX;
          end else begin
            accum = accum * 10 + digit;
          end
        end else if (in_number && !is_op && !is_ws && ch != CH_SEMI && ch != CH_NUL) begin
          // A bad character inside a number drops the number.
          in_number = 1'b0;
          accum     = '0;
          halted    = 1'b1;
          push_token(KIND_ERR, '0, line_now, 1'b1);
        end else if (in_number) begin
          in_number = 1'b0;
          if (ch == CH_SEMI || is_ws) begin
            push_token(KIND_INT, accum, line_now, 1'b1);
            if (is_brk && line_cnt != '1) line_cnt = line_cnt + 1'b1;
          end else begin
            push_token(KIND_INT, accum, line_now, 1'b0);
            push_token(is_op ? op_kind : KIND_END, '0, line_now, 1'b1);
          end
          accum = '0;
        end else if (is_ws) begin
          if (is_brk && line_cnt != '1) line_cnt = line_cnt + 1'b1;
        end else if (is_op) begin
          push_token(op_kind, '0, line_now, 1'b1);
        end else if (ch == CH_NUL) begin
          push_token(KIND_END, '0, line_now, 1'b1);
        end else begin
          halted = 1'b1;
          push_token(KIND_ERR, '0, line_now, 1'b1);
        end
      end
    end
    fail_count  <= n_fail;
    pending     <= expected_tokens.size();
    tokens_seen <= n_tokens;
  end

endmodule

[tb/tb_arithmetic_token_lexer.sv]
// ----------------------------------------------------------------------------
// tb_arithmetic_token_lexer
// Drives character streams into the token lexer with random gaps and output
// stalls: a directed opening, well-formed random expressions, and a final
// syntax error followed by characters that must be swallowed.
// ----------------------------------------------------------------------------
module tb_arithmetic_token_lexer;
  import atl_pkg::*;

  localparam int N_RANDOM = 1700;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 char_valid;
  logic                 char_ready;
  logic [7:0]           char_byte;
  logic                 token_valid;
  logic                 token_ready = 1'b0;
  logic [2:0]           token_kind;
  logic [ACC_W-1:0]     int_value;
  logic [LINE_BITS_DEF-1:0] line_count;
  logic                 last_of_run;

  int fail_count;
  int pending;
  int tokens_seen;

  int    n_sent = 0;
  int    n_after_halt = 0;
  bit    tx_quiet = 1'b0;
  bit    rx_quiet = 1'b0;
  int    stall_left = 0;
  string err_case;

  arithmetic_token_lexer DUT (
    .clk         (clk),
    .rst         (rst),
    .char_valid  (char_valid),
    .char_ready  (char_ready),
    .char_byte   (char_byte),
    .token_valid (token_valid),
    .token_ready (token_ready),
    .token_kind  (token_kind),
    .int_value   (int_value),
    .line_count  (line_count),
    .last_of_run (last_of_run)
  );

  arithmetic_token_lexer_checker token_checker (
    .clk         (clk),
    .rst         (rst),
    .char_valid  (char_valid),
    .char_ready  (char_ready),
    .char_byte   (char_byte),
    .token_valid (token_valid),
    .token_ready (token_ready),
    .token_kind  (token_kind),
    .int_value   (int_value),
    .line_count  (line_count),
    .last_of_run (last_of_run),
    .fail_count  (fail_count),
    .pending     (pending),
    .tokens_seen (tokens_seen)
  );

  always #5 clk = ~clk;

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  function automatic logic [7:0] rand_op();
    case ($urandom_range(0, 3))
      0:       return CH_PLUS;
      1:       return CH_MINUS;
      2:       return CH_STAR;
      default: return CH_SLASH;
    endcase
  endfunction

  function automatic logic [7:0] rand_ws();
    case ($urandom_range(0, 3))
      0:       return CH_SPACE;
      1:       return CH_FF;
      2:       return CH_CR;
      default: return CH_LF;
    endcase
  endfunction

  function automatic bit is_legal(logic [7:0] b);
    return (b >= CH_ZERO && b <= CH_NINE) || b == CH_PLUS || b == CH_MINUS ||
           b == CH_STAR || b == CH_SLASH || b == CH_SEMI || b == CH_SPACE ||
           b == CH_FF || b == CH_CR || b == CH_LF || b == CH_NUL;
  endfunction

  always @(negedge clk) begin
    if (stall_left > 0) begin
      token_ready = 1'b0;
      stall_left--;
    end else begin
      token_ready = 1'b1;
      if (!rx_quiet) stall_left = pick_gap();
    end
    if ($urandom_range(0, 199) == 0) rx_quiet = !rx_quiet;
  end

  task automatic send_char(input logic [7:0] ch);
    int gap;
    gap = tx_quiet ? 0 : pick_gap();
    if ($urandom_range(0, 149) == 0) tx_quiet = !tx_quiet;
    @(negedge clk);
    if (gap > 0) begin
      char_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    char_valid = 1'b1;
    char_byte  = ch;
    @(posedge clk);
    while (!char_ready) @(posedge clk);
    n_sent++;
  endtask

  task automatic send_string(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  // Holds the sender off until every predicted token has been taken.
  task automatic drain_tokens();
    @(negedge clk);
    char_valid = 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    int r;
    int len;
    bit paused;
    logic [7:0] bad;
    rst        = 1'b1;
    char_valid = 1'b0;
    char_byte  = 8'h00;
    paused     = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed opening: whitespace, every operator, every number terminator.
    send_char(CH_SPACE);
    send_char(CH_FF);
    send_char(CH_CR);
    send_char(CH_LF);
    send_string("+-*/7+12-0*3/8;4 6");
    send_char(CH_CR);
    send_char(CH_NINE);
    send_char(CH_NUL);
    send_char(CH_NUL);

    // Random expressions: numbers ended by terminators, with loose filler.
    while (n_sent < N_RANDOM + 26) begin
      if (!paused && n_sent > N_RANDOM / 2) begin
        drain_tokens();
        paused = 1'b1;
      end
      if ($urandom_range(0, 9) < 7) begin
        r = $urandom_range(0, 31);
        if (r == 0) begin
          send_string("9223372036854775807");
        end else if (r == 1) begin
          send_string("9223372036854775808");
        end else begin
          len = (r <= 3) ? $urandom_range(19, 26) : $urandom_range(1, 4);
          for (int i = 0; i < len; i++) send_char(8'(CH_ZERO + $urandom_range(0, 9)));
        end
        r = $urandom_range(0, 15);
        if (r < 8)       send_char(rand_op());
        else if (r < 10) send_char(CH_SEMI);
        else if (r < 14) send_char(rand_ws());
        else if (r < 15) send_char(CH_NUL);
        else             send_char(CH_SPACE);
      end else begin
        r = $urandom_range(0, 9);
        if (r < 5)      send_char(rand_op());
        else if (r < 9) send_char(rand_ws());
        else            send_char(CH_NUL);
      end
    end

    // Close with one syntax error; everything after it must be swallowed.
    do bad = 8'($urandom_range(0, 255)); while (is_legal(bad));
    case ($urandom_range(0, 2))
      0: begin
        err_case = "bad character inside a number";
        send_string("42");
        send_char(bad);
      end
      1: begin
        err_case = "lone semicolon";
        send_char(CH_SPACE);
        send_char(CH_SEMI);
      end
      default: begin
        err_case = "bad character between tokens";
        send_char(CH_SPACE);
        send_char(bad);
      end
    endcase
    drain_tokens();
    repeat (48) begin
      send_char(8'($urandom_range(0, 255)));
      n_after_halt++;
    end
    drain_tokens();
    repeat (20) @(posedge clk);

    $display("Lexed %0d characters (%0d after the halt), compared %0d tokens.",
             n_sent, n_after_halt, tokens_seen);
    $display("The run ended on a syntax error of the kind: %s.", err_case);
    if (fail_count == 0) begin
      $display("PASS arithmetic_token_lexer");
    end else begin
      $display("FAIL arithmetic_token_lexer");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("FAIL arithmetic_token_lexer");
    $finish;
  end

endmodule
